@@ hw/rtl/dtq_pkg.sv @@
// Shared types and constants for the drop-tail queue delay model.
// Holds the controller/datapath command and status structs and field widths.
// No dependencies.
package dtq_pkg;

	localparam int TIME_W    = 48;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CAP_W     = 7;
	localparam int CNT_W     = 32;
	localparam int SUM_W     = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_INGRESS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SERVICE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EGRESS   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd3;

	localparam logic [CFG_W-1:0] INGRESS_RST  = 32'd0;
	localparam logic [CFG_W-1:0] SERVICE_RST  = 32'd1;
	localparam logic [CFG_W-1:0] EGRESS_RST   = 32'd0;
	localparam logic [CAP_W-1:0] CAPACITY_RST = 7'd64;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ARRIVE,
		ST_RETIRE,
		ST_SERVE,
		ST_DEPART,
		ST_E2E_QD,
		ST_E2E_SVC,
		ST_E2E_EGR,
		ST_FINISH
	} state_t;

	// Operand selection for the shared saturating time adder
	typedef enum logic [2:0] {
		ADD_ARRIVE,
		ADD_DEPART,
		ADD_E2E_QD,
		ADD_E2E_SVC,
		ADD_E2E_EGR
	} add_sel_t;

	typedef struct packed {
		logic     load_arr;
		logic     add_en;
		add_sel_t add_sel;
		logic     retire;
		logic     serve;
		logic     finish;
	} cmd_t;

	typedef struct packed {
		logic retire_ok;
		logic drop_now;
	} status_t;

endpackage

@@ hw/rtl/drop_tail_queue_delay_model.sv @@
// Drop-tail queue delay model, top level. Depends on dtq_pkg, dtq_ctrl, dtq_datapath.
// Each input transaction runs arrive, retire, serve and then, unless dropped, depart and the
// end-to-end additions before finishing; departures are retired from the ring one per cycle
// (paced by the ring's single registered read port).
// A new packet is accepted only once the previous one has finished; a pending result does
// not block the next input. Asynchronous reset clears queue state, counters and sums;
// the ring memory has no reset and needs no clearing pass.
module drop_tail_queue_delay_model import dtq_pkg::*; #(
	parameter int QUEUE_DEPTH = 64,
	parameter int TIME_BITS   = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [TIME_W-1:0]    arrival_time,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 was_dropped,
	output logic [CAP_W-1:0]     depth_seen,
	output logic [TIME_W-1:0]    queue_delay,
	output logic [TIME_W-1:0]    departure_time,
	output logic [TIME_W-1:0]    end_to_end_delay,
	output logic [CNT_W-1:0]     delivered_count,
	output logic [CNT_W-1:0]     dropped_count,
	output logic [CAP_W-1:0]     peak_depth,
	output logic [SUM_W-1:0]     total_queue_delay,
	output logic [SUM_W-1:0]     total_e2e_delay
);

	cmd_t    cmd;
	status_t status;

	dtq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	dtq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TIME_BITS   (TIME_BITS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_index         (cfg_index),
		.cfg_wr_data       (cfg_wr_data),
		.arrival_time      (arrival_time),
		.cmd               (cmd),
		.status            (status),
		.was_dropped       (was_dropped),
		.depth_seen        (depth_seen),
		.queue_delay       (queue_delay),
		.departure_time    (departure_time),
		.end_to_end_delay  (end_to_end_delay),
		.delivered_count   (delivered_count),
		.dropped_count     (dropped_count),
		.peak_depth        (peak_depth),
		.total_queue_delay (total_queue_delay),
		.total_e2e_delay   (total_e2e_delay)
	);

endmodule

@@ hw/rtl/dtq_ctrl.sv @@
// Sequencing state machine for the drop-tail queue delay model.
// Drives the datapath through cmd_t and owns the input/output handshakes.
// Depends on dtq_pkg.
module dtq_ctrl import dtq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.add_sel = ADD_ARRIVE;
		in_ready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_arr = 1'b1;
					state_d      = ST_ARRIVE;
				end
			end
			ST_ARRIVE: begin
				cmd.add_en  = 1'b1;
				cmd.add_sel = ADD_ARRIVE;
				state_d     = ST_RETIRE;
			end
			ST_RETIRE: begin
				// drain departed entries from the head, one a cycle
				if (status.retire_ok) begin
					cmd.retire = 1'b1;
				end else begin
					state_d = ST_SERVE;
				end
			end
			ST_SERVE: begin
				cmd.serve = 1'b1;
				state_d   = status.drop_now ? ST_FINISH : ST_DEPART;
			end
			ST_DEPART: begin
				cmd.add_en  = 1'b1;
				cmd.add_sel = ADD_DEPART;
				state_d     = ST_E2E_QD;
			end
			ST_E2E_QD: begin
				cmd.add_en  = 1'b1;
				cmd.add_sel = ADD_E2E_QD;
				state_d     = ST_E2E_SVC;
			end
			ST_E2E_SVC: begin
				cmd.add_en  = 1'b1;
				cmd.add_sel = ADD_E2E_SVC;
				state_d     = ST_E2E_EGR;
			end
			ST_E2E_EGR: begin
				cmd.add_en  = 1'b1;
				cmd.add_sel = ADD_E2E_EGR;
				state_d     = ST_FINISH;
			end
			ST_FINISH: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/dtq_datapath.sv @@
// Datapath of the drop-tail queue delay model: configuration registers,
// departure ring memory, shared saturating time adder, counters and result register.
// Depends on dtq_pkg.
module dtq_datapath import dtq_pkg::*; #(
	parameter int QUEUE_DEPTH = 64,
	parameter int TIME_BITS   = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wr_data,
	input  logic [TIME_W-1:0]    arrival_time,
	input  cmd_t                 cmd,
	output status_t              status,
	output logic                 was_dropped,
	output logic [CAP_W-1:0]     depth_seen,
	output logic [TIME_W-1:0]    queue_delay,
	output logic [TIME_W-1:0]    departure_time,
	output logic [TIME_W-1:0]    end_to_end_delay,
	output logic [CNT_W-1:0]     delivered_count,
	output logic [CNT_W-1:0]     dropped_count,
	output logic [CAP_W-1:0]     peak_depth,
	output logic [SUM_W-1:0]     total_queue_delay,
	output logic [SUM_W-1:0]     total_e2e_delay
);

	localparam int IW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OW   = $clog2(QUEUE_DEPTH + 1);
	localparam int CMPW = ((OW > CAP_W) ? OW : CAP_W) + 1;
	localparam int AW   = (TIME_BITS > TIME_W) ? TIME_BITS : TIME_W;
	localparam int SW   = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
	localparam int TLW  = IW + 2;

	localparam logic [AW-1:0] TMAX_AW = AW'({TIME_BITS{1'b1}});
	localparam logic [SW-1:0] TMAX_SW = SW'({TIME_BITS{1'b1}});

	// configuration
	logic [CFG_W-1:0] ingress_q, service_q, egress_q;
	logic [CAP_W-1:0] capacity_q;

	// queue state
	logic [TIME_BITS-1:0] ring [QUEUE_DEPTH];
	logic [TIME_BITS-1:0] rd_q;
	logic [IW-1:0]        head_q, head_d, head_inc;
	logic [OW-1:0]        occ_q, max_occ_q;
	logic [TIME_BITS-1:0] last_dep_q;

	// per-item work registers
	logic [TIME_BITS-1:0] arr_q, ra_q, start_q, qdelay_q, depart_q, e2e_q;
	logic                 dropped_q;

	// result and statistics registers
	logic                 was_dropped_q;
	logic [CAP_W-1:0]     depth_q;
	logic [TIME_W-1:0]    qdelay_out_q, depart_out_q, e2e_out_q;
	logic [CNT_W-1:0]     delivered_q, dropped_cnt_q;
	logic [SUM_W-1:0]     qsum_q, esum_q;

	// arrival clamp
	logic [AW-1:0]        arr_ext, arr_cl;

	// shared saturating adder
	logic [SW-1:0]        add_a, add_b, add_a_cl;
	logic [SW:0]          add_sum;
	logic [TIME_BITS-1:0] add_res;

	// serve and finish helpers
	logic                 later_last;
	logic [TLW-1:0]       tail_sum, tail_wrap;
	logic [IW-1:0]        tail_idx;
	logic [SUM_W:0]       qsum_add, esum_add;

	assign arr_ext = AW'(arrival_time);
	assign arr_cl  = (arr_ext > TMAX_AW) ? TMAX_AW : arr_ext;

	always_comb begin
		case (cmd.add_sel)
			ADD_ARRIVE: begin
				add_a = SW'(arr_q);
				add_b = SW'(ingress_q);
			end
			ADD_DEPART: begin
				add_a = SW'(start_q);
				add_b = SW'(service_q);
			end
			ADD_E2E_QD: begin
				add_a = SW'(ingress_q);
				add_b = SW'(qdelay_q);
			end
			ADD_E2E_SVC: begin
				add_a = SW'(e2e_q);
				add_b = SW'(service_q);
			end
			ADD_E2E_EGR: begin
				add_a = SW'(e2e_q);
				add_b = SW'(egress_q);
			end
			default: begin
				add_a = '0;
				add_b = '0;
			end
		endcase
	end

	assign add_a_cl = (add_a > TMAX_SW) ? TMAX_SW : add_a;
	assign add_sum  = (SW+1)'(add_a_cl) + (SW+1)'(add_b);
	assign add_res  = (add_sum > (SW+1)'(TMAX_SW)) ? TIME_BITS'(TMAX_SW)
	                                               : TIME_BITS'(add_sum);

	assign head_inc = (32'(head_q) == QUEUE_DEPTH - 1) ? '0 : head_q + 1'b1;
	assign head_d   = cmd.retire ? head_inc : head_q;

	assign status.retire_ok = (occ_q != '0) && (rd_q <= ra_q);
	assign status.drop_now  = (CMPW'(occ_q) >= CMPW'(QUEUE_DEPTH))
	                       || (CMPW'(occ_q) >= CMPW'(capacity_q));

	assign later_last = last_dep_q > ra_q;

	assign tail_sum  = TLW'(head_q) + TLW'(occ_q);
	assign tail_wrap = (tail_sum >= TLW'(QUEUE_DEPTH)) ? tail_sum - TLW'(QUEUE_DEPTH)
	                                                   : tail_sum;
	assign tail_idx  = tail_wrap[IW-1:0];

	assign qsum_add = (SUM_W+1)'(qsum_q) + (SUM_W+1)'(qdelay_q);
	assign esum_add = (SUM_W+1)'(esum_q) + (SUM_W+1)'(e2e_q);

	// ring memory: read follows the next head every cycle
	always_ff @(posedge clk) begin
		rd_q <= ring[head_d];
		if (cmd.finish && !dropped_q) begin
			ring[tail_idx] <= depart_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ingress_q  <= INGRESS_RST;
			service_q  <= SERVICE_RST;
			egress_q   <= EGRESS_RST;
			capacity_q <= CAPACITY_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_INGRESS:  ingress_q  <= cfg_wr_data;
				CFG_SERVICE:  service_q  <= cfg_wr_data;
				CFG_EGRESS:   egress_q   <= cfg_wr_data;
				CFG_CAPACITY: capacity_q <= cfg_wr_data[CAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q        <= '0;
			occ_q         <= '0;
			max_occ_q     <= '0;
			last_dep_q    <= '0;
			delivered_q   <= '0;
			dropped_cnt_q <= '0;
			qsum_q        <= '0;
			esum_q        <= '0;
		end else begin
			if (cmd.retire) begin
				head_q <= head_inc;
				occ_q  <= occ_q - 1'b1;
			end
			if (cmd.finish) begin
				if (occ_q > max_occ_q) begin
					max_occ_q <= occ_q;
				end
				if (dropped_q) begin
					if (dropped_cnt_q != '1) begin
						dropped_cnt_q <= dropped_cnt_q + 1'b1;
					end
				end else begin
					occ_q      <= occ_q + 1'b1;
					last_dep_q <= depart_q;
					if (delivered_q != '1) begin
						delivered_q <= delivered_q + 1'b1;
					end
					qsum_q <= qsum_add[SUM_W] ? '1 : qsum_add[SUM_W-1:0];
					esum_q <= esum_add[SUM_W] ? '1 : esum_add[SUM_W-1:0];
				end
			end
		end
	end

	// work and result registers
	always_ff @(posedge clk) begin
		if (cmd.load_arr) begin
			arr_q <= TIME_BITS'(arr_cl);
		end
		if (cmd.add_en) begin
			case (cmd.add_sel)
				ADD_ARRIVE: ra_q     <= add_res;
				ADD_DEPART: depart_q <= add_res;
				default:    e2e_q    <= add_res;
			endcase
		end
		if (cmd.serve) begin
			dropped_q <= status.drop_now;
			qdelay_q  <= later_last ? last_dep_q - ra_q : '0;
			start_q   <= later_last ? last_dep_q : ra_q;
		end
		if (cmd.finish) begin
			was_dropped_q <= dropped_q;
			depth_q       <= CAP_W'(occ_q);
			qdelay_out_q  <= dropped_q ? '0 : TIME_W'(qdelay_q);
			depart_out_q  <= dropped_q ? '0 : TIME_W'(depart_q);
			e2e_out_q     <= dropped_q ? '0 : TIME_W'(e2e_q);
		end
	end

	assign was_dropped       = was_dropped_q;
	assign depth_seen        = depth_q;
	assign queue_delay       = qdelay_out_q;
	assign departure_time    = depart_out_q;
	assign end_to_end_delay  = e2e_out_q;
	assign delivered_count   = delivered_q;
	assign dropped_count     = dropped_cnt_q;
	assign peak_depth        = CAP_W'(max_occ_q);
	assign total_queue_delay = qsum_q;
	assign total_e2e_delay   = esum_q;

endmodule
